FILE: sv/spi_rtc_register_slave_top_defines.svh
// assertion macros for the spi rtc register slave checker
// expects clk and arst_n in the scope where a macro is used
`ifndef SPI_RTC_REGISTER_SLAVE_TOP_DEFINES_SVH
`define SPI_RTC_REGISTER_SLAVE_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SRRS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define SRRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/srrs_pkg.sv
// shared constants, field widths and bcd helper for the spi rtc register slave
// no dependencies
`default_nettype none

package srrs_pkg;

	// field widths
	localparam int SEC_W  = 6;
	localparam int MIN_W  = 6;
	localparam int HOUR_W = 5;
	localparam int WDAY_W = 3;
	localparam int DAY_W  = 5;
	localparam int MON_W  = 4;
	localparam int YEAR_W = 7;
	localparam int BYTE_W = 8;

	// default sram size
	localparam int SRAM_DEPTH_DEF = 256;

	// transaction kinds
	localparam logic CMD_SELECT = 1'b0;
	localparam logic CMD_XFER   = 1'b1;

	// register map (address bits 6..0)
	localparam logic [6:0] REG_SECONDS   = 7'h00;
	localparam logic [6:0] REG_MINUTES   = 7'h01;
	localparam logic [6:0] REG_HOURS     = 7'h02;
	localparam logic [6:0] REG_WEEKDAY   = 7'h03;
	localparam logic [6:0] REG_DAY       = 7'h04;
	localparam logic [6:0] REG_MONTH     = 7'h05;
	localparam logic [6:0] REG_YEAR      = 7'h06;
	localparam logic [6:0] REG_WRAP      = 7'h13;
	localparam logic [6:0] REG_SRAM_PTR  = 7'h18;
	localparam logic [6:0] REG_SRAM_DATA = 7'h19;

	localparam logic [7:0] WRITE_BIT = 8'h80;
	localparam logic [7:0] PM_FLAG   = 8'h20;
	localparam logic [7:0] IDLE_BYTE = 8'hFF;

	// binary to packed bcd for values below 100
	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [3:0] tens;
		logic [6:0] ones;
		tens = '0;
		for (int t = 1; t < 10; t++) begin
			if (v >= 7'(t * 10)) tens = 4'(t);
		end
		ones = v - (7'(tens) * 7'd10);
		return {tens, ones[3:0]};
	endfunction

endpackage

`default_nettype wire

FILE: sv/srrs_ram.sv
// generic single-port ram with registered read
// no dependencies
`default_nettype none

module srrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write, or read into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/spi_rtc_register_slave_top.sv
// spi rtc register slave: select/byte transactions in, one reply byte out
// depends on srrs_pkg and srrs_ram
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | cmd, select_level, tx_byte, now_* time fields
//  out     | out_valid / out_ready| rx_byte
//
// one transaction per cycle while the output is not stalled; an accepted transaction
// goes to stage 1 (sram read), then to the output register, which offers the reply
// the sram is read or written at most once per transaction, at the decode stage
// reset clears control state and the per-entry valid bits, so the sram reads
// as zero at once with no clearing pass
// a stalled output fills the two stages, then in_ready drops
`default_nettype none

module spi_rtc_register_slave_top #(
	parameter int SRAM_DEPTH = srrs_pkg::SRAM_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        cmd,
	input  wire logic                        select_level,
	input  wire logic [srrs_pkg::BYTE_W-1:0] tx_byte,
	input  wire logic [srrs_pkg::SEC_W-1:0]  now_seconds,
	input  wire logic [srrs_pkg::MIN_W-1:0]  now_minutes,
	input  wire logic [srrs_pkg::HOUR_W-1:0] now_hours,
	input  wire logic [srrs_pkg::WDAY_W-1:0] now_weekday,
	input  wire logic [srrs_pkg::DAY_W-1:0]  now_day,
	input  wire logic [srrs_pkg::MON_W-1:0]  now_month,
	input  wire logic [srrs_pkg::YEAR_W-1:0] now_year,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [srrs_pkg::BYTE_W-1:0] rx_byte
);

	import srrs_pkg::*;

	localparam int IDX_W = $clog2(SRAM_DEPTH);
	localparam logic [11:0] DEP = 12'(SRAM_DEPTH);

	// register state
	logic [7:0]        sram_ptr_q;
	logic [7:0]        addr_q;
	logic              have_addr_q;
	logic              desel_q;
	logic              mode24_q;
	logic [SEC_W-1:0]  lat_sec_q;
	logic [MIN_W-1:0]  lat_min_q;
	logic [HOUR_W-1:0] lat_hour_q;
	logic [WDAY_W-1:0] lat_wday_q;
	logic [DAY_W-1:0]  lat_day_q;
	logic [MON_W-1:0]  lat_mon_q;
	logic [YEAR_W-1:0] lat_year_q;
	logic [SRAM_DEPTH-1:0] ent_vld_q;

	// pipeline and output
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       ram_rd_s1;
	logic       ent_vld_s1;
	logic       out_vld_q;
	logic [7:0] rx_q;

	// decode results
	logic       accept;
	logic       advance;
	logic [7:0] nxt_addr;
	logic       nxt_have;
	logic       nxt_desel;
	logic       do_latch;
	logic       mode_load;
	logic       ptr_load;
	logic       ptr_inc;
	logic       ram_rd;
	logic       ram_wr;
	logic [7:0] reply;
	logic [7:0] inc_addr;
	logic [6:0] sel_reg;
	logic [7:0] reg_byte;
	logic [IDX_W-1:0] idx;
	logic [11:0] rem;
	logic [7:0] ram_rdata;
	logic [7:0] s1_byte;

	// time register views
	logic [5:0] hour_p11;
	logic [3:0] hour12;
	logic [7:0] hour_bcd;
	logic [6:0] year_mod;

	// handshake
	assign advance  = !out_vld_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;
	assign out_valid = out_vld_q;
	assign rx_byte   = rx_q;

	// sram index: pointer modulo depth by restoring subtraction (quotient < 16)
	always_comb begin
		rem = {4'b0, sram_ptr_q};
		for (int k = 3; k >= 0; k--) begin
			if (rem >= (DEP << k)) rem = rem - (DEP << k);
		end
		idx = rem[IDX_W-1:0];
	end

	// address auto-increment, wrapping after REG_WRAP and holding on REG_SRAM_DATA
	always_comb begin
		priority if (addr_q[6:0] == REG_WRAP) begin
			inc_addr = addr_q & WRITE_BIT;
		end else if (addr_q[6:0] == REG_SRAM_DATA) begin
			inc_addr = addr_q;
		end else begin
			inc_addr = addr_q + 8'd1;
		end
	end

	// hour register in either mode
	always_comb begin
		hour_p11 = 6'(lat_hour_q) + 6'd11;
		priority if (hour_p11 >= 6'd36) begin
			hour12 = 4'(hour_p11 - 6'd36);
		end else if (hour_p11 >= 6'd24) begin
			hour12 = 4'(hour_p11 - 6'd24);
		end else if (hour_p11 >= 6'd12) begin
			hour12 = 4'(hour_p11 - 6'd12);
		end else begin
			hour12 = 4'(hour_p11);
		end
		if (mode24_q) begin
			hour_bcd = to_bcd(7'(lat_hour_q));
		end else begin
			hour_bcd = to_bcd(7'(hour12) + 7'd1);
			if (lat_hour_q > 5'd11) hour_bcd = hour_bcd | PM_FLAG;
		end
		year_mod = (lat_year_q >= 7'd100) ? (lat_year_q - 7'd100) : lat_year_q;
	end

	// register addressed by this byte
	assign sel_reg = have_addr_q ? inc_addr[6:0] : tx_byte[6:0];

	// register read mux, for addresses with the write bit clear
	always_comb begin
		unique case (sel_reg)
			REG_SECONDS:  reg_byte = to_bcd(7'(lat_sec_q));
			REG_MINUTES:  reg_byte = to_bcd(7'(lat_min_q));
			REG_HOURS:    reg_byte = hour_bcd;
			REG_WEEKDAY:  reg_byte = 8'(lat_wday_q) + 8'd1;
			REG_DAY:      reg_byte = to_bcd(7'(lat_day_q));
			REG_MONTH:    reg_byte = to_bcd(7'(lat_mon_q) + 7'd1);
			REG_YEAR:     reg_byte = to_bcd(year_mod);
			REG_SRAM_PTR: reg_byte = sram_ptr_q;
			default:      reg_byte = 8'h00;
		endcase
	end

	// transaction decode
	always_comb begin
		nxt_addr  = addr_q;
		nxt_have  = have_addr_q;
		nxt_desel = desel_q;
		do_latch  = 1'b0;
		mode_load = 1'b0;
		ptr_load  = 1'b0;
		ptr_inc   = 1'b0;
		ram_rd    = 1'b0;
		ram_wr    = 1'b0;
		reply     = IDLE_BYTE;
		if (cmd == CMD_SELECT) begin
			do_latch  = desel_q && !select_level;
			nxt_desel = select_level;
			if (select_level) nxt_have = 1'b0;
		end else if (!desel_q) begin
			nxt_addr = have_addr_q ? inc_addr : tx_byte;
			nxt_have = 1'b1;
			if (!have_addr_q && tx_byte[7]) begin
				// address byte of a write: nothing else happens
				reply = IDLE_BYTE;
			end else if (nxt_addr[7]) begin
				unique case (nxt_addr[6:0])
					REG_HOURS:     mode_load = 1'b1;
					REG_SRAM_PTR:  ptr_load  = 1'b1;
					REG_SRAM_DATA: begin
						ram_wr  = 1'b1;
						ptr_inc = 1'b1;
					end
					default: ;
				endcase
			end else begin
				reply = reg_byte;
				if (nxt_addr[6:0] == REG_SRAM_DATA) begin
					ram_rd  = 1'b1;
					ptr_inc = 1'b1;
				end
			end
		end
	end

	// control state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sram_ptr_q  <= '0;
			addr_q      <= '0;
			have_addr_q <= 1'b0;
			desel_q     <= 1'b1;
			mode24_q    <= 1'b1;
			lat_sec_q   <= '0;
			lat_min_q   <= '0;
			lat_hour_q  <= '0;
			lat_wday_q  <= '0;
			lat_day_q   <= '0;
			lat_mon_q   <= '0;
			lat_year_q  <= '0;
			ent_vld_q   <= '0;
		end else if (accept) begin
			addr_q      <= nxt_addr;
			have_addr_q <= nxt_have;
			desel_q     <= nxt_desel;
			if (mode_load) mode24_q <= tx_byte[7];
			if (ptr_load) begin
				sram_ptr_q <= tx_byte;
			end else if (ptr_inc) begin
				sram_ptr_q <= sram_ptr_q + 8'd1;
			end
			if (ram_wr) ent_vld_q[idx] <= 1'b1;
			if (do_latch) begin
				lat_sec_q  <= now_seconds;
				lat_min_q  <= now_minutes;
				lat_hour_q <= now_hours;
				lat_wday_q <= now_weekday;
				lat_day_q  <= now_day;
				lat_mon_q  <= now_month;
				lat_year_q <= now_year;
			end
		end
	end

	// sram storage, read data held until the next read
	srrs_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(SRAM_DEPTH)
	) u_sram (
		.clk  (clk),
		.en   (accept && (ram_rd || ram_wr)),
		.we   (ram_wr),
		.addr (idx),
		.wdata(tx_byte),
		.rdata(ram_rdata)
	);

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1    <= reply;
			ram_rd_s1  <= ram_rd;
			ent_vld_s1 <= ent_vld_q[idx];
		end
	end

	// never-written entries read as zero
	assign s1_byte = ram_rd_s1 ? (ent_vld_s1 ? ram_rdata : 8'h00) : byte_s1;

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= valid_s1;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (advance && valid_s1) rx_q <= s1_byte;
	end

endmodule

`default_nettype wire

FILE: sv/srrs_checker.sv
// port-level checks on the spi rtc register slave, bound to the top level
// depends on srrs_pkg and spi_rtc_register_slave_top_defines.svh
`include "spi_rtc_register_slave_top_defines.svh"
`default_nettype none

module srrs_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [srrs_pkg::BYTE_W-1:0] rx_byte
);

	// an empty output register means the decode stage can take a transaction
	`SRRS_ASSERT_SAME(a_ready_when_out_empty, !out_valid, in_ready, "in_ready low with empty output")

	// an accepted transaction is followed by a reply showing, through stage 1 and the output register
	`SRRS_ASSERT_SAME(a_reply_follows, in_valid && in_ready, ##2 out_valid, "reply missing after accept")

	// nothing is offered right after reset
	`SRRS_ASSERT_SAME(a_quiet_after_reset, $rose(arst_n), !out_valid, "output valid out of reset")

	// a stalled reply holds
	`SRRS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(rx_byte), "stalled reply changed")

endmodule

bind spi_rtc_register_slave_top srrs_checker u_srrs_checker (.*);

`default_nettype wire

FILE: sim/tb_spi_rtc_register_slave_top.sv
// self-checking bench for the spi rtc register slave: directed rows, then framed random traffic
// replies are predicted by a local register and sram mirror and compared in order
// depends on srrs_pkg and spi_rtc_register_slave_top
module tb_spi_rtc_register_slave_top;
	timeunit 1ns;
	timeprecision 1ps;

	import srrs_pkg::*;

	localparam int RAM_WORDS = SRAM_DEPTH_DEF;
	localparam int N_ROWS    = 35;

	// addresses used by the directed rows and the frame generator
	localparam logic [6:0] REG_TOP         = 7'h7F;
	localparam logic [7:0] RD_BEFORE_WRAP  = {1'b0, REG_WRAP - 7'd1};
	localparam logic [7:0] RD_HOURS        = {1'b0, REG_HOURS};
	localparam logic [7:0] RD_TOP          = {1'b0, REG_TOP};
	localparam logic [7:0] RD_PTR          = {1'b0, REG_SRAM_PTR};
	localparam logic [7:0] RD_DATA         = {1'b0, REG_SRAM_DATA};
	localparam logic [7:0] WR_BEFORE_HOURS = WRITE_BIT | {1'b0, REG_MINUTES};
	localparam logic [7:0] WR_BEFORE_PTR   = WRITE_BIT | {1'b0, REG_SRAM_PTR - 7'd1};
	localparam logic [7:0] MODE_12H        = 8'h00;

	typedef logic [SEC_W-1:0]  sec_t;
	typedef logic [MIN_W-1:0]  min_t;
	typedef logic [HOUR_W-1:0] hour_t;
	typedef logic [WDAY_W-1:0] wday_t;
	typedef logic [DAY_W-1:0]  mday_t;
	typedef logic [MON_W-1:0]  month_t;
	typedef logic [YEAR_W-1:0] year_t;

	typedef struct packed {
		sec_t   secs;
		min_t   mins;
		hour_t  hours;
		wday_t  wday;
		mday_t  mday;
		month_t month;
		year_t  year;
	} clock_stamp_t;

	typedef struct packed {
		logic              cmd;
		logic              level;
		logic [BYTE_W-1:0] tx;
		clock_stamp_t      stamp;
		logic              known;
		logic [BYTE_W-1:0] known_reply;
	} rtc_txn_t;

	typedef struct packed {
		logic        cmd;
		logic        level;
		logic [7:0]  tx;
		logic        use_b;
		logic        known;
		logic [7:0]  reply;
	} dir_row_t;

	// top of every field, and every field outside its range
	localparam clock_stamp_t STAMP_A = '{6'd59, 6'd59, 5'd23, 3'd6, 5'd31, 4'd11, 7'd99};
	localparam clock_stamp_t STAMP_B = '{6'd63, 6'd63, 5'd31, 3'd7, 5'd0, 4'd15, 7'd127};

	// directed rows: cmd, level, tx, stamp b, reply known, reply
	localparam dir_row_t DIR_ROWS [N_ROWS] = '{
		'{CMD_XFER,   1'b1, IDLE_BYTE,       1'b0, 1'b1, IDLE_BYTE}, // byte while deselected
		'{CMD_SELECT, 1'b1, 8'h00,           1'b0, 1'b1, IDLE_BYTE}, // deselect while deselected
		'{CMD_SELECT, 1'b0, 8'h00,           1'b0, 1'b1, IDLE_BYTE}, // select, latch stamp a
		'{CMD_XFER,   1'b0, RD_BEFORE_WRAP,  1'b0, 1'b1, 8'h00},     // unmapped register
		'{CMD_XFER,   1'b0, 8'h00,           1'b0, 1'b1, 8'h00},     // last before wrap
		'{CMD_XFER,   1'b0, 8'h00,           1'b0, 1'b0, 8'h00},     // wraps to seconds
		'{CMD_SELECT, 1'b0, 8'h00,           1'b1, 1'b1, IDLE_BYTE}, // select again, no relatch
		'{CMD_XFER,   1'b0, 8'h00,           1'b0, 1'b1, 8'h59},     // minutes
		'{CMD_XFER,   1'b0, 8'h00,           1'b0, 1'b1, 8'h23},     // hours, 24-hour
		'{CMD_SELECT, 1'b1, 8'h00,           1'b0, 1'b1, IDLE_BYTE},
		'{CMD_SELECT, 1'b0, 8'h00,           1'b1, 1'b1, IDLE_BYTE}, // latch stamp b
		'{CMD_XFER,   1'b0, WR_BEFORE_HOURS, 1'b1, 1'b1, IDLE_BYTE}, // write address byte
		'{CMD_XFER,   1'b0, MODE_12H,        1'b1, 1'b1, IDLE_BYTE}, // switch to 12-hour
		'{CMD_SELECT, 1'b1, 8'h00,           1'b0, 1'b1, IDLE_BYTE},
		'{CMD_SELECT, 1'b0, 8'h00,           1'b1, 1'b1, IDLE_BYTE},
		'{CMD_XFER,   1'b0, RD_HOURS,        1'b1, 1'b1, 8'h27},     // hour 31 in 12-hour form
		'{CMD_XFER,   1'b0, 8'h00,           1'b1, 1'b1, 8'h08},     // weekday 7
		'{CMD_XFER,   1'b0, 8'h00,           1'b1, 1'b1, 8'h00},     // day 0
		'{CMD_XFER,   1'b0, 8'h00,           1'b1, 1'b1, 8'h16},     // month 15
		'{CMD_XFER,   1'b0, 8'h00,           1'b1, 1'b1, 8'h27},     // year 127
		'{CMD_SELECT, 1'b1, 8'h00,           1'b0, 1'b1, IDLE_BYTE},
		'{CMD_SELECT, 1'b0, 8'h00,           1'b0, 1'b1, IDLE_BYTE},
		'{CMD_XFER,   1'b0, WR_BEFORE_PTR,   1'b0, 1'b1, IDLE_BYTE},
		'{CMD_XFER,   1'b0, 8'hFF,           1'b0, 1'b1, IDLE_BYTE}, // pointer to last word
		'{CMD_XFER,   1'b0, 8'hA5,           1'b0, 1'b1, IDLE_BYTE}, // data, pointer wraps
		'{CMD_XFER,   1'b0, 8'h5A,           1'b0, 1'b1, IDLE_BYTE}, // data address holds
		'{CMD_SELECT, 1'b1, 8'h00,           1'b0, 1'b1, IDLE_BYTE},
		'{CMD_SELECT, 1'b0, 8'h00,           1'b0, 1'b1, IDLE_BYTE},
		'{CMD_XFER,   1'b0, RD_TOP,          1'b0, 1'b1, 8'h00},
		'{CMD_XFER,   1'b0, 8'h00,           1'b0, 1'b1, IDLE_BYTE}, // carry sets write bit
		'{CMD_SELECT, 1'b1, 8'h00,           1'b0, 1'b1, IDLE_BYTE},
		'{CMD_SELECT, 1'b0, 8'h00,           1'b0, 1'b1, IDLE_BYTE},
		'{CMD_XFER,   1'b0, RD_PTR,          1'b0, 1'b1, 8'h01},
		'{CMD_XFER,   1'b0, 8'h00,           1'b0, 1'b0, 8'h00},     // sram word never written
		'{CMD_SELECT, 1'b1, 8'h00,           1'b0, 1'b1, IDLE_BYTE}
	};

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              cmd;
	logic              select_level;
	logic [BYTE_W-1:0] tx_byte;
	sec_t              now_seconds;
	min_t              now_minutes;
	hour_t             now_hours;
	wday_t             now_weekday;
	mday_t             now_day;
	month_t            now_month;
	year_t             now_year;
	logic              out_valid;
	logic              out_ready;
	logic [BYTE_W-1:0] rx_byte;

	// mirror of the slave state
	logic [7:0]   m_ram [RAM_WORDS];
	logic [7:0]   m_ptr;
	logic [7:0]   m_addr;
	logic         m_have_addr;
	logic         m_desel;
	logic         m_mode24;
	clock_stamp_t m_stamp;

	rtc_txn_t   txn_backlog [$];
	logic [7:0] expected_rx_q [$];

	int burst_left;
	int rx_hold_request;
	int txn_count;
	int directed_count;
	int reply_count;
	int fail_count;
	int hour12_reads;
	int sram_data_ops;
	int addr_wraps;
	int dir_flips;

	spi_rtc_register_slave_top #(
		.SRAM_DEPTH(RAM_WORDS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.select_level(select_level),
		.tx_byte(tx_byte),
		.now_seconds(now_seconds),
		.now_minutes(now_minutes),
		.now_hours(now_hours),
		.now_weekday(now_weekday),
		.now_day(now_day),
		.now_month(now_month),
		.now_year(now_year),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.rx_byte(rx_byte)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit, far above the slowest legal run
	initial begin
		#2_000_000;
		$display("timeout with %0d replies outstanding", expected_rx_q.size());
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [7:0] bcd_byte(input int unsigned v);
		return 8'(((v / 10) << 4) + (v % 10));
	endfunction

	// advance the mirror by one transaction and return the reply byte
	function automatic logic [7:0] predict_rx_byte(input rtc_txn_t t);
		logic [6:0] reg_idx;
		logic [7:0] r;
		int unsigned h;
		if (t.cmd == CMD_SELECT) begin
			if (m_desel && !t.level) m_stamp = t.stamp;
			if (t.level) m_have_addr = 1'b0;
			m_desel = t.level;
			return IDLE_BYTE;
		end
		if (m_desel) return IDLE_BYTE;
		// address byte, or auto-increment ahead of every later byte
		if (!m_have_addr) begin
			m_addr = t.tx;
			m_have_addr = 1'b1;
			if ((m_addr & WRITE_BIT) != 0) return IDLE_BYTE;
		end else if (m_addr[6:0] == REG_WRAP) begin
			m_addr = m_addr & WRITE_BIT;
			addr_wraps++;
		end else if (m_addr[6:0] != REG_SRAM_DATA) begin
			if (m_addr[6:0] == REG_TOP) dir_flips++;
			m_addr = m_addr + 8'd1;
		end
		reg_idx = m_addr[6:0];
		if ((m_addr & WRITE_BIT) != 0) begin
			case (reg_idx)
				REG_HOURS: m_mode24 = t.tx[7];
				REG_SRAM_PTR: m_ptr = t.tx;
				REG_SRAM_DATA: begin
					m_ram[m_ptr % RAM_WORDS] = t.tx;
					m_ptr = m_ptr + 8'd1;
					sram_data_ops++;
				end
				default: ;
			endcase
			return IDLE_BYTE;
		end
		case (reg_idx)
			REG_SECONDS: r = bcd_byte(m_stamp.secs);
			REG_MINUTES: r = bcd_byte(m_stamp.mins);
			REG_HOURS: begin
				h = m_stamp.hours;
				if (m_mode24) begin
					r = bcd_byte(h);
				end else begin
					r = bcd_byte(((h + 11) % 12) + 1);
					if (h > 11) r = r | PM_FLAG;
					hour12_reads++;
				end
			end
			REG_WEEKDAY: r = 8'(int'(m_stamp.wday) + 1);
			REG_DAY: r = bcd_byte(m_stamp.mday);
			REG_MONTH: r = bcd_byte(int'(m_stamp.month) + 1);
			REG_YEAR: r = bcd_byte(int'(m_stamp.year) % 100);
			REG_SRAM_PTR: r = m_ptr;
			REG_SRAM_DATA: begin
				r = m_ram[m_ptr % RAM_WORDS];
				m_ptr = m_ptr + 8'd1;
				sram_data_ops++;
			end
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// mostly legal clock values, now and then any bit pattern
	function automatic clock_stamp_t random_stamp();
		clock_stamp_t s;
		bit any;
		any = ($urandom_range(0, 7) == 0);
		s.secs  = any ? sec_t'($urandom())   : sec_t'($urandom_range(0, 60));
		s.mins  = any ? min_t'($urandom())   : min_t'($urandom_range(0, 59));
		s.hours = any ? hour_t'($urandom())  : hour_t'($urandom_range(0, 23));
		s.wday  = any ? wday_t'($urandom())  : wday_t'($urandom_range(0, 6));
		s.mday  = any ? mday_t'($urandom())  : mday_t'($urandom_range(1, 31));
		s.month = any ? month_t'($urandom()) : month_t'($urandom_range(0, 11));
		s.year  = any ? year_t'($urandom())  : year_t'($urandom_range(0, 99));
		return s;
	endfunction

	function automatic rtc_txn_t select_txn(input logic lvl);
		rtc_txn_t t;
		t = '0;
		t.cmd = CMD_SELECT;
		t.level = lvl;
		t.tx = 8'($urandom());
		t.stamp = random_stamp();
		return t;
	endfunction

	function automatic rtc_txn_t xfer_txn(input logic [7:0] b);
		rtc_txn_t t;
		t = '0;
		t.cmd = CMD_XFER;
		t.level = 1'($urandom());
		t.tx = b;
		t.stamp = random_stamp();
		return t;
	endfunction

	// one stretch of random traffic: mostly select frames, some noise
	task automatic queue_frame();
		int kind;
		int nbytes;
		int r;
		logic [7:0] first;
		logic [7:0] ptr;
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(0, 1) != 0) txn_backlog.push_back(xfer_txn(8'($urandom())));
				else txn_backlog.push_back(select_txn(1'($urandom())));
			end
			return;
		end
		// sram write, pointer reload, then read back the same words
		if (kind < 22) begin
			ptr = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 7))
				: 8'(8'hF8 + $urandom_range(0, 7));
			nbytes = $urandom_range(1, 6);
			txn_backlog.push_back(select_txn(1'b0));
			txn_backlog.push_back(xfer_txn(WR_BEFORE_PTR));
			txn_backlog.push_back(xfer_txn(ptr));
			repeat (nbytes) txn_backlog.push_back(xfer_txn(8'($urandom())));
			txn_backlog.push_back(select_txn(1'b1));
			txn_backlog.push_back(select_txn(1'b0));
			txn_backlog.push_back(xfer_txn(WR_BEFORE_PTR));
			txn_backlog.push_back(xfer_txn(ptr));
			txn_backlog.push_back(select_txn(1'b1));
			txn_backlog.push_back(select_txn(1'b0));
			txn_backlog.push_back(xfer_txn(RD_DATA));
			repeat (nbytes - 1) txn_backlog.push_back(xfer_txn(8'($urandom())));
			txn_backlog.push_back(select_txn(1'b1));
			return;
		end
		// pick a start address near the interesting corners
		case ($urandom_range(0, 9))
			0: first = {1'b0, 7'($urandom_range(0, 6))};
			1: first = {1'b0, REG_WRAP - 7'($urandom_range(0, 3))};
			2: first = ($urandom_range(0, 1) != 0) ? RD_PTR : RD_DATA;
			3: first = WR_BEFORE_HOURS;
			4: first = WRITE_BIT | {1'b0, REG_SRAM_DATA - 7'($urandom_range(0, 2))};
			5: first = {1'b0, REG_TOP - 7'($urandom_range(0, 2))};
			6: first = WRITE_BIT | {1'b0, REG_TOP - 7'($urandom_range(0, 2))};
			7: first = WRITE_BIT | {1'b0, REG_WRAP - 7'($urandom_range(0, 1))};
			default: first = 8'($urandom());
		endcase
		if ($urandom_range(0, 5) == 0) txn_backlog.push_back(xfer_txn(8'($urandom())));
		txn_backlog.push_back(select_txn(1'b0));
		if ($urandom_range(0, 9) == 0) txn_backlog.push_back(select_txn(1'b0));
		txn_backlog.push_back(xfer_txn(first));
		nbytes = $urandom_range(0, 8);
		repeat (nbytes) begin
			r = $urandom_range(0, 29);
			if (r == 0) txn_backlog.push_back(select_txn(1'b0));
			else if (r == 1) txn_backlog.push_back(select_txn(1'b1));
			txn_backlog.push_back(xfer_txn(8'($urandom())));
		end
		if ($urandom_range(0, 6) != 0) txn_backlog.push_back(select_txn(1'b1));
	endtask

	// offer the backlog in bursts, or back to back when steady
	task automatic drive_backlog(input bit steady);
		rtc_txn_t t;
		logic [7:0] want;
		int gap;
		while (txn_backlog.size() != 0) begin
			if (!steady && burst_left == 0) begin
				if ($urandom_range(0, 7) == 0) begin
					gap = 0;
					burst_left = $urandom_range(40, 80);
				end else begin
					gap = $urandom_range(0, 6);
					burst_left = $urandom_range(1, 20);
				end
				repeat (gap) begin
					in_valid <= 1'b0;
					@(negedge clk);
				end
			end
			t = txn_backlog.pop_front();
			in_valid     <= 1'b1;
			cmd          <= t.cmd;
			select_level <= t.level;
			tx_byte      <= t.tx;
			now_seconds  <= t.stamp.secs;
			now_minutes  <= t.stamp.mins;
			now_hours    <= t.stamp.hours;
			now_weekday  <= t.stamp.wday;
			now_day      <= t.stamp.mday;
			now_month    <= t.stamp.month;
			now_year     <= t.stamp.year;
			do @(posedge clk); while (in_ready !== 1'b1);
			want = predict_rx_byte(t);
			if (t.known) want = t.known_reply;
			expected_rx_q.push_back(want);
			txn_count++;
			if (burst_left > 0) burst_left--;
			@(negedge clk);
		end
	endtask

	// sender holds off until every reply is back
	task automatic wait_until_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (expected_rx_q.size() != 0);
	endtask

	task automatic log_failure(input string msg);
		fail_count++;
		if (fail_count <= 10) $display("%0t ns: %s", $time, msg);
	endtask

	// receiver: long hold-off on request, otherwise phases of stall styles
	initial begin
		int hold_left;
		int phase_left;
		int style;
		int step;
		logic [7:0] mask;
		hold_left = 0;
		phase_left = 0;
		style = 0;
		step = 0;
		mask = 8'hFF;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_request > 0) begin
				hold_left = rx_hold_request;
				rx_hold_request = 0;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				if (phase_left == 0) begin
					style = $urandom_range(0, 3);
					phase_left = $urandom_range(20, 120);
					mask = 8'($urandom()) | 8'h01;
				end
				phase_left--;
				step++;
				case (style)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= mask[step % 8];
					default: out_ready <= ($urandom_range(0, 2) == 0);
				endcase
			end
		end
	end

	// reply checker
	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && out_valid && out_ready) begin
			reply_count++;
			if (expected_rx_q.size() == 0) begin
				log_failure($sformatf("unexpected reply rx_byte=%02h", rx_byte));
			end else begin
				want = expected_rx_q.pop_front();
				if (rx_byte !== want)
					log_failure($sformatf("rx_byte expected %02h got %02h", want, rx_byte));
			end
		end
	end

	// main sequence
	initial begin
		rtc_txn_t row_txn;
		int n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_SELECT;
		select_level = 1'b1;
		tx_byte = '0;
		now_seconds = '0;
		now_minutes = '0;
		now_hours = '0;
		now_weekday = '0;
		now_day = '0;
		now_month = '0;
		now_year = '0;
		burst_left = 0;
		rx_hold_request = 0;
		txn_count = 0;
		reply_count = 0;
		fail_count = 0;
		hour12_reads = 0;
		sram_data_ops = 0;
		addr_wraps = 0;
		dir_flips = 0;
		foreach (m_ram[i]) m_ram[i] = 8'h00;
		m_ptr = 8'h00;
		m_addr = 8'h00;
		m_have_addr = 1'b0;
		m_desel = 1'b1;
		m_mode24 = 1'b1;
		m_stamp = '0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed rows
		for (int i = 0; i < N_ROWS; i++) begin
			row_txn = '0;
			row_txn.cmd = DIR_ROWS[i].cmd;
			row_txn.level = DIR_ROWS[i].level;
			row_txn.tx = DIR_ROWS[i].tx;
			row_txn.stamp = DIR_ROWS[i].use_b ? STAMP_B : STAMP_A;
			row_txn.known = DIR_ROWS[i].known;
			row_txn.known_reply = DIR_ROWS[i].reply;
			txn_backlog.push_back(row_txn);
		end
		drive_backlog(1'b0);
		directed_count = txn_count;
		wait_until_drained();

		// output held off while the sender keeps offering: input must back up
		rx_hold_request = 96;
		while (txn_backlog.size() < 32) queue_frame();
		drive_backlog(1'b1);
		wait_until_drained();

		// framed random traffic in chunks
		for (int chunk = 0; chunk < 3; chunk++) begin
			while (txn_backlog.size() < 100) queue_frame();
			drive_backlog(1'b0);
			if (chunk == 1) wait_until_drained();
		end
		in_valid <= 1'b0;

		// drain, then keep idle to catch stray replies
		for (n = 0; n < 20000 && expected_rx_q.size() != 0; n++) @(posedge clk);
		repeat (8) @(posedge clk);
		if (expected_rx_q.size() != 0)
			log_failure($sformatf("%0d replies never arrived", expected_rx_q.size()));

		$display("%0d transactions (%0d directed), %0d replies checked, %0d failures",
			txn_count, directed_count, reply_count, fail_count);
		$display("hits: %0d 12-hour hour reads, %0d sram data accesses, %0d wraps, %0d carries",
			hour12_reads, sram_data_ops, addr_wraps, dir_flips);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
